FILE: rtl/pfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver package
// Shared types and constants for the interleaved PCM to stereo unpacker.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  // Register reset values.
  localparam logic [2:0] SAMPLE_BYTES_RESET  = 3'd2;
  localparam logic [7:0] CHANNEL_COUNT_RESET = 8'd2;

  // Sample size limits.
  localparam logic [2:0] SAMPLE_BYTES_MIN = 3'd1;
  localparam logic [2:0] SAMPLE_BYTES_MAX = 3'd4;
  localparam logic [1:0] TOP_LANE         = 2'd3;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } pfd_item_t;

  // One stereo result.
  typedef struct packed {
    logic [31:0] right_sample;
    logic [31:0] left_sample;
    logic        last_frame;
  } pfd_result_t;

  // Result hand-off from the unpack logic to the output register.
  typedef struct packed {
    logic        valid;
    pfd_result_t result;
  } pfd_res_bus_t;

endpackage

FILE: rtl/pfd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver input register
// Holds one accepted word until the unpack logic consumes it.
// ----------------------------------------------------------------------------
module pfd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfd_pkg::pfd_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output pfd_pkg::pfd_item_t item
);
  import pfd_pkg::*;

  logic      valid_r, valid_nxt;
  pfd_item_t item_r;
  logic      accept;

  // A held word blocks the input until it moves on.
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Occupancy of the input register.
  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/pfd_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver unpack logic
// Places each byte into its channel word and tracks byte and channel counts.
// ----------------------------------------------------------------------------
module pfd_unpack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           sample_bytes,
  input  logic [7:0]           channel_count,
  input  logic                 item_valid,
  input  pfd_pkg::pfd_item_t   item,
  input  logic                 out_ready,
  output logic                 advance,
  output pfd_pkg::pfd_res_bus_t res
);
  import pfd_pkg::*;

  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  chan_pos_r, chan_pos_nxt;
  logic [31:0] first_word_r, first_word_nxt;
  logic [31:0] second_word_r, second_word_nxt;

  logic [2:0]  sb_eff;
  logic [7:0]  cc_eff;
  logic [2:0]  lane_sum;
  logic [1:0]  lane;
  logic [31:0] byte_word;
  logic [31:0] lane_mask;
  logic [31:0] placed_first;
  logic [31:0] placed_second;
  logic        sample_done;
  logic        frame_done;

  // Out-of-range settings fold to the nearest legal value.
  always_comb begin
    if (sample_bytes < SAMPLE_BYTES_MIN) begin
      sb_eff = SAMPLE_BYTES_MIN;
    end else if (sample_bytes > SAMPLE_BYTES_MAX) begin
      sb_eff = SAMPLE_BYTES_MAX;
    end else begin
      sb_eff = sample_bytes;
    end
    cc_eff = (channel_count == 8'd0) ? 8'd1 : channel_count;
  end

  // Byte lane for left justification; lanes past the top clamp to the top.
  assign lane_sum  = {1'b0, byte_pos_r} + 3'd4 - sb_eff;
  assign lane      = (lane_sum > {1'b0, TOP_LANE}) ? TOP_LANE : lane_sum[1:0];
  assign byte_word = {24'd0, item.data_byte} << {lane, 3'b000};
  assign lane_mask = 32'h0000_00FF << {lane, 3'b000};

  // The first byte of a sample clears the other lanes.
  assign placed_first  = (byte_pos_r == 2'd0) ? byte_word
                                               : ((first_word_r & ~lane_mask) | byte_word);
  assign placed_second = (byte_pos_r == 2'd0) ? byte_word
                                               : ((second_word_r & ~lane_mask) | byte_word);

  assign sample_done = ({1'b0, byte_pos_r} >= (sb_eff - 3'd1));
  assign frame_done  = sample_done && (chan_pos_r >= (cc_eff - 8'd1));

  // A word without a result never waits on the output side.
  assign advance = item_valid && (!frame_done || out_ready);

  // Next state for the counters and channel words.
  always_comb begin
    first_word_nxt  = first_word_r;
    second_word_nxt = second_word_r;
    if (chan_pos_r == 8'd0) begin
      first_word_nxt = placed_first;
    end else if (chan_pos_r == 8'd1) begin
      second_word_nxt = placed_second;
    end

    if (sample_done) begin
      byte_pos_nxt = 2'd0;
      chan_pos_nxt = frame_done ? 8'd0 : (chan_pos_r + 8'd1);
    end else begin
      byte_pos_nxt = byte_pos_r + 2'd1;
      chan_pos_nxt = chan_pos_r;
    end

    // Buffer end drops any partial frame.
    if (item.buffer_end) begin
      byte_pos_nxt = 2'd0;
      chan_pos_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= 2'd0;
      chan_pos_r    <= 8'd0;
      first_word_r  <= 32'd0;
      second_word_r <= 32'd0;
    end else if (advance) begin
      byte_pos_r    <= byte_pos_nxt;
      chan_pos_r    <= chan_pos_nxt;
      first_word_r  <= first_word_nxt;
      second_word_r <= second_word_nxt;
    end
  end

  // Result for a completed frame; mono copies the first channel.
  always_comb begin
    res.valid               = advance && frame_done;
    res.result.right_sample = first_word_nxt;
    res.result.left_sample  = (cc_eff == 8'd1) ? first_word_nxt : second_word_nxt;
    res.result.last_frame   = item.buffer_end;
  end

endmodule

FILE: rtl/pfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver output register
// Holds one stereo word until the downstream side takes it.
// ----------------------------------------------------------------------------
module pfd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfd_pkg::pfd_res_bus_t res,
  output logic                  out_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pfd_pkg::pfd_result_t  out_result
);
  import pfd_pkg::*;

  logic        valid_r, valid_nxt;
  pfd_result_t result_r;

  // Room for a new word when empty or when the held one leaves now.
  assign out_ready = !valid_r || !out_stall;

  always_comb begin
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result_r <= res.result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: rtl/pcm_frame_deinterleaver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver
// Unpacks an interleaved little-endian PCM byte stream into left-justified
// stereo words, one word per completed frame.
// ----------------------------------------------------------------------------
//  Port group  Direction  Handshake          Word
//  in_         input      in_valid/in_stall  data_byte, buffer_end
//  out_        output     out_valid/out_stall right_sample, left_sample,
//                                            last_frame
//  cfg_        input      cfg_we             sample_bytes, channel_count
//
//  One byte is taken every cycle while no frame-completing byte waits on a
//  stalled output; the rate is set by the single unpack step between the
//  input register and the output register. out_valid rises once the byte
//  completing a frame has passed the unpack logic into the output register.
//  Reset is synchronous, clears the counters and channel words and returns
//  the settings to their defaults.
//  While a result waits under out_stall, bytes that complete no frame still
//  flow; a byte that completes a frame waits for the output register.
// ----------------------------------------------------------------------------
module pcm_frame_deinterleaver_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_buffer_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_right_sample,
  output logic [31:0]                      out_left_sample,
  output logic                             out_last_frame,
  input  logic                             cfg_we,
  input  logic [pfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfd_pkg::*;

  logic [2:0]   sample_bytes_r;
  logic [7:0]   channel_count_r;
  pfd_item_t    in_item;
  pfd_item_t    item;
  logic         item_valid;
  logic         advance;
  logic         out_ready;
  pfd_res_bus_t res;
  pfd_result_t  out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bytes_r  <= SAMPLE_BYTES_RESET;
      channel_count_r <= CHANNEL_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_BYTES:  sample_bytes_r  <= cfg_data[2:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.data_byte  = in_data_byte;
  assign in_item.buffer_end = in_buffer_end;

  pfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pfd_unpack u_unpack (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_bytes  (sample_bytes_r),
    .channel_count (channel_count_r),
    .item_valid    (item_valid),
    .item          (item),
    .out_ready     (out_ready),
    .advance       (advance),
    .res           (res)
  );

  pfd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_right_sample = out_result.right_sample;
  assign out_left_sample  = out_result.left_sample;
  assign out_last_frame   = out_result.last_frame;

endmodule

FILE: rtl/pfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame deinterleaver port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module pfd_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_right_sample,
  input logic [31:0] out_left_sample,
  input logic        out_last_frame
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_right_sample)
      && $stable(out_left_sample) && $stable(out_last_frame))
    else $error("stalled result word changed or dropped");

  // The input only stalls behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A fresh result follows an earlier accepted input byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input byte");

endmodule

bind pcm_frame_deinterleaver_top pfd_port_checker u_pfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_right_sample (out_right_sample),
  .out_left_sample  (out_left_sample),
  .out_last_frame   (out_last_frame)
);
